// ----- rtl/mpig_pkg.sv -----
// ----------------------------------------------------------------------------
// mpig_pkg
// Shared types, codes and defaults for the M-RoPE position id generator.
// ----------------------------------------------------------------------------
package mpig_pkg;

  localparam int unsigned GRID_WIDTH_DEF = 16;
  localparam int unsigned POS_WIDTH_DEF  = 32;
  localparam int unsigned MS_W           = 5;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [7:0] TT_TEXT  = 8'd0;
  localparam logic [7:0] TT_IMAGE = 8'd1;
  localparam logic [7:0] TT_VIDEO = 8'd2;

  localparam logic [MS_W-1:0] MERGE_DIV_RST = 5'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_DIV  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROPE_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_IMAGES = 3'd3;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_TYPE,
    ST_RUN_SIZE,
    ST_IMG_COUNT
  } status_e;

  typedef enum logic [1:0] {
    PT_NONE,
    PT_TEXT,
    PT_IMAGE,
    PT_OTHER
  } prev_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOSE,
    S_DIV_H,
    S_WAIT_H,
    S_DIV_W,
    S_WAIT_W,
    S_EXEC,
    S_LAST_CLOSE,
    S_PUSH
  } seq_state_e;

  typedef struct packed {
    logic [MS_W-1:0] merge_div;
    logic [30:0]     seq_base;
    logic [30:0]     rope_base;
    logic [7:0]      expected_images;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  token_type;
    logic [15:0] grid_t;
    logic [15:0] grid_h;
    logic [15:0] grid_w;
    logic        seq_last;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        pos_t;
    logic [30:0]        pos_h;
    logic [30:0]        pos_w;
    status_e            status;
    logic signed [31:0] position_delta;
    logic               done_res;
  } out_item_t;

endpackage

// ----- rtl/mpig_div.sv -----
// ----------------------------------------------------------------------------
// mpig_div
// Restoring divider, one quotient bit per cycle, grid value by merge size.
// ----------------------------------------------------------------------------
module mpig_div import mpig_pkg::*; #(
  parameter int unsigned GRID_WIDTH = GRID_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [GRID_WIDTH-1:0] dividend_i,
  input  logic [MS_W-1:0]       divisor_i,
  output logic                  done_o,
  output logic [GRID_WIDTH-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(GRID_WIDTH + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [MS_W-1:0]       rem_q;
  logic [GRID_WIDTH-1:0] quo_q;

  logic [MS_W:0] rem_sh;
  logic [MS_W:0] rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, quo_q[GRID_WIDTH-1]};
  assign ge      = rem_sh >= {1'b0, divisor_i};
  assign rem_sub = rem_sh - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(GRID_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[MS_W-1:0] : rem_sh[MS_W-1:0];
      quo_q <= {quo_q[GRID_WIDTH-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/mpig_core.sv -----
// ----------------------------------------------------------------------------
// mpig_core
// Token sequencer: run bookkeeping, meshgrid walk and result assembly.
// ----------------------------------------------------------------------------
module mpig_core import mpig_pkg::*; #(
  parameter int unsigned GRID_WIDTH = GRID_WIDTH_DEF,
  parameter int unsigned POS_WIDTH  = POS_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o
);

  localparam int unsigned G = GRID_WIDTH;
  localparam int unsigned P = POS_WIDTH;

  seq_state_e state_q, state_d;

  in_item_t          item_q;
  logic [P-1:0]      pos_q;
  prev_e             prev_q;
  logic [2:0][G-1:0] dim_q;
  logic [2:0][G-1:0] cnt_q;
  logic [G-1:0]      adv_q;
  logic [7:0]        images_q;
  logic [31:0]       tok_q;
  status_e           status_q;
  logic [G-1:0]      qh_q;
  logic [P-1:0]      rt_q, rh_q, rw_q;
  logic [31:0]       end_base_q;

  logic              div_start;
  logic [G-1:0]      div_dividend;
  logic [MS_W-1:0]   ms;
  logic              div_done;
  logic [G-1:0]      div_quot;

  logic              is_img_in;
  logic              is_img;
  logic              mesh_full;
  logic [G-1:0]      c2n, c1n;
  logic [2:0][G-1:0] cnt_adv;

  assign ms           = (cfg_i.merge_div == '0) ? MS_W'(1) : cfg_i.merge_div;
  assign div_dividend = (state_q == S_DIV_W) ? G'(item_q.grid_w) : G'(item_q.grid_h);
  assign is_img_in    = in_item_i.token_type == TT_IMAGE;
  assign is_img       = item_q.token_type == TT_IMAGE;
  assign mesh_full    = (dim_q[0] == '0) || (dim_q[1] == '0) || (dim_q[2] == '0) ||
                        (cnt_q[0] >= dim_q[0]);

  mpig_div #(
    .GRID_WIDTH(GRID_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (ms),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // meshgrid step, w fastest
  always_comb begin
    c2n     = cnt_q[2] + G'(1);
    c1n     = cnt_q[1] + G'(1);
    cnt_adv = cnt_q;
    if (c2n >= dim_q[2]) begin
      cnt_adv[2] = '0;
      if (c1n >= dim_q[1]) begin
        cnt_adv[1] = '0;
        cnt_adv[0] = cnt_q[0] + G'(1);
      end else begin
        cnt_adv[1] = c1n;
      end
    end else begin
      cnt_adv[2] = c2n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (prev_q == PT_IMAGE && !is_img_in) begin
            state_d = S_CLOSE;
          end else if (is_img_in && prev_q != PT_IMAGE) begin
            state_d = S_DIV_H;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_CLOSE: state_d = S_EXEC;
      S_DIV_H: begin
        div_start = 1'b1;
        state_d   = S_WAIT_H;
      end
      S_WAIT_H: begin
        if (div_done) begin
          state_d = S_DIV_W;
        end
      end
      S_DIV_W: begin
        div_start = 1'b1;
        state_d   = S_WAIT_W;
      end
      S_WAIT_W: begin
        if (div_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = (is_img && item_q.seq_last) ? S_LAST_CLOSE : S_PUSH;
      S_LAST_CLOSE: state_d = S_PUSH;
      S_PUSH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      prev_q   <= PT_NONE;
      dim_q    <= '0;
      cnt_q    <= '0;
      adv_q    <= '0;
      images_q <= '0;
      tok_q    <= '0;
      status_q <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tok_q    <= tok_q + 32'd1;
            status_q <= ST_OK;
            if (tok_q == '0) begin
              pos_q <= P'(cfg_i.rope_base);
            end
          end
        end
        S_CLOSE, S_LAST_CLOSE: begin
          if (!mesh_full) begin
            status_q <= ST_RUN_SIZE;
          end
          pos_q <= pos_q + P'(adv_q);
        end
        S_WAIT_W: begin
          if (div_done) begin
            dim_q[0] <= G'(item_q.grid_t);
            dim_q[1] <= qh_q;
            dim_q[2] <= div_quot;
            cnt_q    <= '0;
            adv_q    <= (qh_q > div_quot) ? qh_q : div_quot;
            if (images_q != 8'd255) begin
              images_q <= images_q + 8'd1;
            end
          end
        end
        S_EXEC: begin
          if (item_q.token_type == TT_TEXT) begin
            pos_q  <= pos_q + P'(1);
            prev_q <= PT_TEXT;
          end else if (is_img) begin
            if (mesh_full) begin
              status_q <= ST_RUN_SIZE;
            end else begin
              cnt_q <= cnt_adv;
            end
            prev_q <= PT_IMAGE;
          end else begin
            status_q <= ST_BAD_TYPE;
            prev_q   <= PT_OTHER;
          end
        end
        S_PUSH: begin
          if (res_ready_i && item_q.seq_last) begin
            pos_q    <= P'(cfg_i.rope_base);
            prev_q   <= PT_NONE;
            dim_q    <= '0;
            cnt_q    <= '0;
            adv_q    <= '0;
            images_q <= '0;
            tok_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_q <= in_item_i;
        end
      end
      S_WAIT_H: begin
        if (div_done) begin
          qh_q <= div_quot;
        end
      end
      S_EXEC: begin
        end_base_q <= 32'(cfg_i.seq_base) + tok_q;
        if (is_img && !mesh_full) begin
          rt_q <= pos_q + P'(cnt_q[0]);
          rh_q <= pos_q + P'(cnt_q[1]);
          rw_q <= pos_q + P'(cnt_q[2]);
        end else begin
          rt_q <= pos_q;
          rh_q <= pos_q;
          rw_q <= pos_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.pos_t    = 31'(rt_q);
    res_o.pos_h    = 31'(rh_q);
    res_o.pos_w    = 31'(rw_q);
    res_o.done_res = item_q.seq_last;
    if (item_q.seq_last && status_q == ST_OK && images_q != cfg_i.expected_images) begin
      res_o.status = ST_IMG_COUNT;
    end else begin
      res_o.status = status_q;
    end
    if (item_q.seq_last) begin
      res_o.position_delta = 32'(pos_q) - end_base_q;
    end else begin
      res_o.position_delta = '0;
    end
  end

endmodule

// ----- rtl/mrope_position_id_generator_top.sv -----
// ----------------------------------------------------------------------------
// mrope_position_id_generator_top
// Multimodal rotary position ids: one t/h/w id triple per token.
//
// Channels: cfg (index, data) writes one of four registers, always ready;
// in carries one token per transaction; out returns one result per token.
// Configure only while the block is idle.
// The block takes one token at a time and drops in_ready_o until that
// token's result is loaded into the output register. A text token or an
// image token inside a run steps through the execute and push states to the
// output register; a token that closes an image run, or a last image token,
// also steps through a close state. The first token of an image run divides
// grid height and width by merge size on one shared divider, one quotient
// bit per cycle, before it executes. These sequencer steps and the divider
// set the token rate, with the divide only at run start.
// Reset clears all sequence state and loads the register defaults
// (merge size 2, others zero). When out_ready_i is low the result waits in
// the output register; the next token can still be accepted and run, and it
// waits at its last step until the output register is free.
// ----------------------------------------------------------------------------
module mrope_position_id_generator_top import mpig_pkg::*; #(
  parameter int unsigned GRID_WIDTH = GRID_WIDTH_DEF,
  parameter int unsigned POS_WIDTH  = POS_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o
);

  cfg_t      cfg_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  assign cfg_ready_o = 1'b1;
  assign res_ready   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.merge_div       <= MERGE_DIV_RST;
      cfg_q.seq_base        <= '0;
      cfg_q.rope_base       <= '0;
      cfg_q.expected_images <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MERGE_DIV:  cfg_q.merge_div       <= cfg_data_i[MS_W-1:0];
        CFG_SEQ_BASE:   cfg_q.seq_base        <= cfg_data_i[30:0];
        CFG_ROPE_BASE:  cfg_q.rope_base       <= cfg_data_i[30:0];
        CFG_EXP_IMAGES: cfg_q.expected_images <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mpig_core #(
    .GRID_WIDTH(GRID_WIDTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_one_token_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("token accepted while previous token still in work");

  a_delta_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.done_res |-> out_item_o.position_delta == '0)
    else $error("position delta set on a non-final token");

  a_count_error_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_IMG_COUNT |-> out_item_o.done_res)
    else $error("image count status on a non-final token");

endmodule

// ----- test/mrope_position_id_generator_top_tb.sv -----
// ----------------------------------------------------------------------------
// mrope_position_id_generator_top_tb
// Self-checking regression for the M-RoPE position id generator.
//
// Tokens are driven over the valid/ready input channel and results are
// drained over the output channel, with random gaps and stalls on both sides.
// A scoreboard class carries its own copy of the sequence state and the
// registers. It computes the t/h/w ids, status and delta for every accepted
// token and compares each result transaction field by field against the
// oldest one outstanding. A short directed pass covers the error codes and
// the value extremes. Random sequences follow: mostly well-formed image runs
// between text tokens, plus noise and broken runs. Register settings change
// between groups of sequences, once the block has drained.
// ----------------------------------------------------------------------------
module mrope_position_id_generator_top_tb import mpig_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  class mrope_id_board;
    logic [MS_W-1:0] merge_div;
    logic [30:0]     seq_base;
    logic [30:0]     rope_base;
    logic [7:0]      exp_images;
    logic [31:0]     run_pos;
    logic [31:0]     img_adv;
    logic [31:0]     tokens;
    logic [31:0]     dims [3];
    logic [31:0]     cnt [3];
    logic [7:0]      images_seen;
    prev_e           prev;
    out_item_t       pending_ids [$];
    int              errors;

    function new();
      merge_div  = MERGE_DIV_RST;
      seq_base   = '0;
      rope_base  = '0;
      exp_images = '0;
      errors     = 0;
      clear_seq();
      run_pos = '0;
    endfunction

    function void clear_seq();
      run_pos = 32'(rope_base);
      prev    = PT_NONE;
      foreach (dims[i]) begin
        dims[i] = '0;
        cnt[i]  = '0;
      end
      img_adv     = '0;
      images_seen = '0;
      tokens      = '0;
    endfunction

    function bit grid_done();
      return dims[0] == '0 || dims[1] == '0 || dims[2] == '0 || cnt[0] >= dims[0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MERGE_DIV:  merge_div = data[MS_W-1:0];
        CFG_SEQ_BASE:   seq_base = data[30:0];
        CFG_ROPE_BASE:  rope_base = data[30:0];
        CFG_EXP_IMAGES: exp_images = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_token(in_item_t tok);
      out_item_t   ids;
      logic [31:0] ms;
      logic [31:0] gh;
      logic [31:0] gw;
      logic [31:0] pt;
      logic [31:0] ph;
      logic [31:0] pw;
      status_e     st;
      ms = (merge_div == '0) ? 32'd1 : 32'(merge_div);
      gh = 32'(tok.grid_h);
      gw = 32'(tok.grid_w);
      st = ST_OK;
      if (tokens == '0) run_pos = 32'(rope_base);
      tokens++;
      // a non-image token closes an open image run
      if (prev == PT_IMAGE && tok.token_type != TT_IMAGE) begin
        if (!grid_done()) st = ST_RUN_SIZE;
        run_pos += img_adv;
      end
      pt = run_pos;
      ph = run_pos;
      pw = run_pos;
      if (tok.token_type == TT_TEXT) begin
        run_pos++;
        prev = PT_TEXT;
      end else if (tok.token_type == TT_IMAGE) begin
        if (prev != PT_IMAGE) begin
          dims[0] = 32'(tok.grid_t);
          dims[1] = gh / ms;
          dims[2] = gw / ms;
          foreach (cnt[i]) cnt[i] = '0;
          img_adv = ((gh > gw) ? gh : gw) / ms;
          if (images_seen != 8'hFF) images_seen++;
        end
        if (grid_done()) begin
          st = ST_RUN_SIZE;
        end else begin
          pt = run_pos + cnt[0];
          ph = run_pos + cnt[1];
          pw = run_pos + cnt[2];
          cnt[2]++;
          if (cnt[2] >= dims[2]) begin
            cnt[2] = '0;
            cnt[1]++;
            if (cnt[1] >= dims[1]) begin
              cnt[1] = '0;
              cnt[0]++;
            end
          end
        end
        prev = PT_IMAGE;
        if (tok.seq_last) begin
          if (!grid_done()) st = ST_RUN_SIZE;
          run_pos += img_adv;
        end
      end else begin
        st   = ST_BAD_TYPE;
        prev = PT_OTHER;
      end
      ids.pos_t          = pt[30:0];
      ids.pos_h          = ph[30:0];
      ids.pos_w          = pw[30:0];
      ids.position_delta = '0;
      ids.done_res       = tok.seq_last;
      if (tok.seq_last) begin
        if (st == ST_OK && images_seen != exp_images) st = ST_IMG_COUNT;
        ids.position_delta = run_pos - (32'(seq_base) + tokens);
        clear_seq();
      end
      ids.status = st;
      pending_ids.push_back(ids);
    endfunction

    function void field_eq(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_ids(out_item_t got);
      out_item_t want;
      if (pending_ids.size() == 0) begin
        $error("result transaction with no token outstanding");
        errors++;
        return;
      end
      want = pending_ids.pop_front();
      field_eq("pos_t", want.pos_t, got.pos_t);
      field_eq("pos_h", want.pos_h, got.pos_h);
      field_eq("pos_w", want.pos_w, got.pos_w);
      field_eq("status", want.status, got.status);
      field_eq("position_delta", want.position_delta, got.position_delta);
      field_eq("done_res", want.done_res, got.done_res);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;

  mrope_id_board sb = new();
  int            hold_cycles = 0;
  bit            no_gaps = 1'b0;
  int            sent = 0;

  mrope_position_id_generator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic in_item_t make_token(logic [7:0] tt, logic [15:0] gt, logic [15:0] gh,
                                          logic [15:0] gw, logic last);
    in_item_t tok;
    tok.token_type = tt;
    tok.grid_t     = gt;
    tok.grid_h     = gh;
    tok.grid_w     = gw;
    tok.seq_last   = last;
    return tok;
  endfunction

  function automatic logic [30:0] pick_start();
    case ($urandom_range(9))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'h7FFF_FFFF - 31'($urandom_range(0, 20));
      3: return 31'($urandom());
      default: return 31'($urandom_range(0, 5000));
    endcase
  endfunction

  task automatic write_regs(input logic [MS_W-1:0] ms, input logic [30:0] ss,
                            input logic [30:0] mr, input logic [7:0] ei);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    logic [CFG_DATA_W-1:0] keep [4];
    logic [CFG_DATA_W-1:0] data;
    idx  = '{CFG_MERGE_DIV, CFG_SEQ_BASE, CFG_ROPE_BASE, CFG_EXP_IMAGES};
    val  = '{32'(ms), 32'(ss), 32'(mr), 32'(ei)};
    keep = '{32'h1F, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFF};
    foreach (idx[i]) begin
      // junk above the register width must be dropped
      data = val[i] | ($urandom() & ~keep[i]);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      sb.write_reg(idx[i], data);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_token(input in_item_t tok);
    if (!no_gaps) begin
      while ($urandom_range(99) < 12) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_item_i  <= tok;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_token(tok);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_queue(input in_item_t q [$]);
    foreach (q[i]) send_token(q[i]);
  endtask

  task automatic close_phase();
    in_valid_i <= 1'b0;
    while (sb.pending_ids.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic run_sequence(input bit tidy);
    in_item_t seq_q [$];
    int       ms;
    int       n_img;
    int       gt;
    int       gh_m;
    int       gw_m;
    int       len;
    int       lo;
    ms = (sb.merge_div == '0) ? 1 : int'(sb.merge_div);
    if (tidy) n_img = (sb.exp_images <= 8'd6) ? int'(sb.exp_images) : $urandom_range(0, 6);
    else n_img = $urandom_range(0, 4);
    for (int k = 0; k <= n_img; k++) begin
      lo = (tidy && k > 0 && k < n_img) ? 1 : 0;
      repeat ($urandom_range(lo, 3))
        seq_q.push_back(make_token(TT_TEXT, 16'($urandom), 16'($urandom), 16'($urandom),
                                   1'b0));
      if (!tidy && $urandom_range(2) == 0)
        seq_q.push_back(make_token(8'($urandom_range(0, 255)), 16'($urandom),
                                   16'($urandom), 16'($urandom), 1'b0));
      if (k < n_img) begin
        gt   = $urandom_range(1, 2);
        gh_m = $urandom_range(1, 3);
        gw_m = $urandom_range(1, 3);
        len  = gt * gh_m * gw_m;
        if (!tidy && $urandom_range(1) == 0) len = $urandom_range(1, len + 2);
        seq_q.push_back(make_token(TT_IMAGE, 16'(gt),
                                   16'(gh_m * ms + $urandom_range(0, ms - 1)),
                                   16'(gw_m * ms + $urandom_range(0, ms - 1)), 1'b0));
        repeat (len - 1)
          seq_q.push_back(make_token(TT_IMAGE, 16'($urandom), 16'($urandom),
                                     16'($urandom), 1'b0));
      end
    end
    if (seq_q.size() == 0)
      seq_q.push_back(make_token(TT_TEXT, 16'($urandom), 16'($urandom), 16'($urandom),
                                 1'b0));
    seq_q[seq_q.size() - 1].seq_last = 1'b1;
    send_queue(seq_q);
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1)
      sb.check_ids(out_item_o);
  end

  initial begin
    in_item_t        dir_q [$];
    int              phase;
    logic [MS_W-1:0] ms;
    logic [7:0]      ei;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MERGE_DIV;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    phase       = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset register values: full run, errors of every kind, image count off
    dir_q.push_back(make_token(TT_TEXT, 16'h0, 16'h0, 16'h0, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd1, 16'd4, 16'd5, 1'b0));
    repeat (3) dir_q.push_back(make_token(TT_IMAGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    dir_q.push_back(make_token(TT_TEXT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    dir_q.push_back(make_token(TT_VIDEO, 16'd0, 16'd0, 16'd0, 1'b0));
    dir_q.push_back(make_token(8'hFF, 16'hFFFF, 16'h0, 16'hFFFF, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd1, 16'd2, 16'd2, 1'b0));
    dir_q.push_back(make_token(TT_TEXT, 16'd0, 16'd0, 16'd0, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd1, 16'd2, 16'd6, 1'b0));
    dir_q.push_back(make_token(TT_TEXT, 16'd0, 16'd0, 16'd0, 1'b0));
    dir_q.push_back(make_token(TT_TEXT, 16'd0, 16'd0, 16'd0, 1'b1));
    send_queue(dir_q);
    close_phase();

    // merge size zero, starts at the top of the range, wrap of positions
    write_regs(5'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 8'd1);
    dir_q.delete();
    dir_q.push_back(make_token(TT_TEXT, 16'd0, 16'd0, 16'd0, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd1, 16'd1, 16'd1, 1'b1));
    dir_q.push_back(make_token(TT_IMAGE, 16'd2, 16'd2, 16'd1, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd0, 16'd0, 16'd0, 1'b1));
    dir_q.push_back(make_token(8'd7, 16'd0, 16'd0, 16'd0, 1'b1));
    send_queue(dir_q);
    close_phase();

    // merge size 16, zero merged height, exact run closed by seq_last
    write_regs(5'd16, 31'd0, 31'h12345, 8'd2);
    dir_q.delete();
    dir_q.push_back(make_token(TT_IMAGE, 16'hFFFF, 16'd15, 16'h8000, 1'b0));
    dir_q.push_back(make_token(TT_TEXT, 16'd0, 16'd0, 16'd0, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd1, 16'd32, 16'd16, 1'b0));
    dir_q.push_back(make_token(TT_IMAGE, 16'd0, 16'd0, 16'd0, 1'b1));
    send_queue(dir_q);
    close_phase();

    while (sent < 1950) begin
      phase++;
      no_gaps = (phase % 7 == 3);
      case ($urandom_range(9))
        0: ms = 5'd0;
        1: ms = 5'd16;
        2: ms = 5'd1;
        default: ms = 5'($urandom_range(2, 4));
      endcase
      if (phase == 4) begin
        // image count saturation
        write_regs(5'd1, pick_start(), pick_start(), 8'hFF);
        for (int k = 0; k < 258; k++) begin
          send_token(make_token(TT_IMAGE, 16'd1, 16'd1, 16'd1, 1'b0));
          send_token(make_token(TT_TEXT, 16'($urandom), 16'($urandom), 16'($urandom),
                                k == 257));
        end
      end else begin
        ei = ($urandom_range(19) == 0) ? 8'hFF : 8'($urandom_range(0, 4));
        write_regs(ms, pick_start(), pick_start(), ei);
        if (phase == 2 || $urandom_range(14) == 0) hold_cycles = 300;
        repeat ($urandom_range(1, 3)) run_sequence($urandom_range(6) != 0);
      end
      close_phase();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_ids.size() == 0) begin
      $display("mrope_position_id_generator_top regression: pass");
    end else begin
      $display("mrope_position_id_generator_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("mrope_position_id_generator_top regression: fail");
    $finish;
  end

endmodule

// ----- mrope_position_id_generator_top.f -----
rtl/mpig_pkg.sv
rtl/mpig_div.sv
rtl/mpig_core.sv
rtl/mrope_position_id_generator_top.sv
test/mrope_position_id_generator_top_tb.sv
